>>> rtl/core/assert_macros.svh
// Assertion helpers for the range-minimum block.
// Both macros sample on clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STMIN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STMIN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stmin_pkg.sv
`timescale 1ns / 1ps

package stmin_pkg;

  localparam int LEAF_COUNT  = 1024;
  localparam int LEAF_W      = $clog2(LEAF_COUNT);
  localparam int NODE_AW     = LEAF_W + 1;
  localparam int STORE_DEPTH = 2 * LEAF_COUNT;
  localparam int POS_W       = NODE_AW + 1;
  localparam int CNT_W       = 11;
  localparam int VAL_W       = 30;
  localparam int IDX_W       = 10;

  localparam logic [VAL_W-1:0] MIN_IDENTITY = 30'h3f3f3f3f;
  localparam logic [CNT_W-1:0] CNT_RESET    = 11'd1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] element_value;
    logic [CNT_W-1:0] range_start;
    logic [CNT_W-1:0] range_end;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] minimum;
    logic             status;
  } out_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
    logic [NODE_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_stat_t;

  // Clamp a written count to [1, LEAF_COUNT].
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] v;
    v = c;
    if (v == '0) v = CNT_W'(1);
    if (v > CNT_W'(LEAF_COUNT)) v = CNT_W'(LEAF_COUNT);
    return v;
  endfunction

  // Smallest power of two not below c (c >= 1): smear the bits of c-1.
  function automatic logic [CNT_W-1:0] pow2_ceil(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] v;
    v = c - CNT_W'(1);
    v = v | (v >> 1);
    v = v | (v >> 2);
    v = v | (v >> 4);
    v = v | (v >> 8);
    return v + CNT_W'(1);
  endfunction

  function automatic logic [VAL_W-1:0] vmin(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> rtl/core/stmin_ram.sv
`timescale 1ns / 1ps

module stmin_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/stmin_ctrl.sv
`timescale 1ns / 1ps

module stmin_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  stmin_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output stmin_pkg::out_t              out_data,
  input  logic [stmin_pkg::CNT_W-1:0]  cnt,
  input  logic [stmin_pkg::CNT_W-1:0]  base,
  output stmin_pkg::mem_req_t          mem_req,
  input  logic [stmin_pkg::VAL_W-1:0]  rd_data,
  output stmin_pkg::ctrl_stat_t        stat
);
  import stmin_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_B_RD0, S_B_RD1, S_B_WR, S_Q_LEFT, S_Q_RIGHT, S_Q_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [NODE_AW-1:0] clr_r, clr_nxt;
  logic [LEAF_W-1:0]  bi_r, bi_nxt;
  logic [VAL_W-1:0]   tmp_r, tmp_nxt;
  logic [POS_W-1:0]   l_r, l_nxt, r_r, r_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic               stat_r, stat_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               accept;
  logic [CNT_W-1:0]   hi_c;
  logic [VAL_W-1:0]   sat_val;
  logic [POS_W-1:0]   r_dec, r_sel;
  mem_req_t           req;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign hi_c    = (in_data.range_end > cnt) ? cnt : in_data.range_end;
  assign sat_val = (in_data.element_value > MIN_IDENTITY) ? MIN_IDENTITY
                                                          : in_data.element_value;
  assign r_dec   = r_r - POS_W'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    bi_nxt        = bi_r;
    tmp_nxt       = tmp_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    stat_nxt      = stat_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    acc_nxt       = pend_r ? vmin(acc_r, rd_data) : acc_r;
    r_sel         = r_r;
    req           = '0;

    unique case (state_r)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
        clr_nxt   = clr_r + NODE_AW'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            CMD_LOAD: begin
              if (CNT_W'(in_data.element_index) < cnt) begin
                req.we    = 1'b1;
                req.waddr = NODE_AW'(base) + NODE_AW'(in_data.element_index);
                req.wdata = sat_val;
              end
            end
            CMD_BUILD: begin
              bi_nxt    = LEAF_W'(base - CNT_W'(1));
              state_nxt = S_B_RD0;
            end
            CMD_QUERY: begin
              stat_nxt = in_data.range_end > cnt;
              acc_nxt  = MIN_IDENTITY;
              l_nxt    = POS_W'(in_data.range_start) + POS_W'(base);
              r_nxt    = POS_W'(hi_c) + POS_W'(base);
              state_nxt = (in_data.range_start < hi_c) ? S_Q_LEFT : S_Q_FIN;
            end
            default: ;
          endcase
        end
      end
      S_B_RD0: begin
        req.raddr = {bi_r, 1'b0};
        state_nxt = (bi_r == '0) ? S_IDLE : S_B_RD1;
      end
      S_B_RD1: begin
        tmp_nxt   = rd_data;
        req.raddr = {bi_r, 1'b1};
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        req.we    = 1'b1;
        req.waddr = NODE_AW'(bi_r);
        req.wdata = vmin(tmp_r, rd_data);
        bi_nxt    = bi_r - LEAF_W'(1);
        state_nxt = S_B_RD0;
      end
      S_Q_LEFT: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            req.raddr = l_r[NODE_AW-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + POS_W'(1);
          end
          state_nxt = S_Q_RIGHT;
        end else begin
          state_nxt = S_Q_FIN;
        end
      end
      S_Q_RIGHT: begin
        if (r_r[0]) begin
          req.raddr = r_dec[NODE_AW-1:0];
          pend_nxt  = 1'b1;
          r_sel     = r_dec;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_sel >> 1;
        state_nxt = S_Q_LEFT;
      end
      S_Q_FIN: begin
        // last pending read was folded into acc_r on the way in
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.minimum = acc_r;
          out_data_nxt.status  = stat_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bi_r       <= bi_nxt;
    tmp_r      <= tmp_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign mem_req       = req;
  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.busy     = (state_r != S_IDLE) && (state_r != S_CLEAR);

endmodule

>>> rtl/core/segment_tree_range_min.sv
// Range-minimum segment tree over a single node memory.
//
// in_valid/in_ready/in_data carry load, build and query requests; a query
// yields one result on out_valid/out_ready/out_data, the others none.
// cfg_we/cfg_data set the element count (clamped to 1..1024); write it only
// while the block is idle. Leaf base is the power-of-two ceiling of it.
//
// Load: writes one leaf. Build: two reads on the one read port and one write
// per internal node. Query: a left and a right step per tree level (at most
// one node read each), result registered.
// One request is worked at a time; in_ready is high only when idle.
//
// After reset a clearing pass writes zero to all 2048 nodes, one per cycle;
// in_ready stays low until the pass ends. If the receiver stalls, the
// result waits in the output register; the next request is still taken,
// and a following query holds in its last step until the slot frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_tree_range_min (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  stmin_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output stmin_pkg::out_t             out_data,
  input  logic                        cfg_we,
  input  logic [stmin_pkg::CNT_W-1:0] cfg_data
);
  import stmin_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  mem_req_t         mem_req;
  logic [VAL_W-1:0] rd_data;
  ctrl_stat_t       stat;

  always_comb begin
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    if (cfg_we) begin
      cnt_nxt  = eff_count(cfg_data);
      base_nxt = pow2_ceil(eff_count(cfg_data));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= eff_count(CNT_RESET);
      base_r <= pow2_ceil(eff_count(CNT_RESET));
    end else begin
      cnt_r  <= cnt_nxt;
      base_r <= base_nxt;
    end
  end

  stmin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cnt       (cnt_r),
    .base      (base_r),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  stmin_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  `STMIN_ASSERT_NOW(a_clear_blocks, stat.clearing, !in_ready, "request taken during clear")
  `STMIN_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_data.command == CMD_QUERY, stat.busy && !in_ready, "query did not start")
  `STMIN_ASSERT_NOW(a_min_bound, out_valid, out_data.minimum <= MIN_IDENTITY, "minimum above identity")
  `STMIN_ASSERT_NOW(a_base_cover, 1'b1, base_r >= cnt_r && cnt_r != '0, "leaf base below count")

endmodule

>>> sim/tb_segment_tree_range_min.sv
`timescale 1ns / 1ps

module tb_segment_tree_range_min;
  import stmin_pkg::*;

  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  // covers the longest build, at leaf base 1024, with some margin
  localparam int         SETTLE_CYCLES = 3 * LEAF_COUNT + 64;
  localparam int         MAX_REPORTS   = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;

  segment_tree_range_min u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // mirror of the node memory and of the written element count
  logic [VAL_W-1:0] tree_mirror [0:STORE_DEPTH-1];
  logic [CNT_W-1:0] count_setting;
  out_t             pending_minima[$];

  int sender_gap_pct;
  int receiver_stall_pct;
  int cycle_count;
  int error_count;
  int requests_sent;
  int minima_checked;
  int settings_used;

  always #5 clk = ~clk;

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
             pending_minima.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamped_count();
    int unsigned c;
    c = 32'(count_setting);
    if (c == 0) c = 1;
    if (c > LEAF_COUNT) c = LEAF_COUNT;
    return c;
  endfunction

  function automatic int unsigned leaf_base_for(input int unsigned cnt);
    int unsigned b;
    b = 1;
    while (b < cnt) b = b << 1;
    return b;
  endfunction

  function automatic logic [VAL_W-1:0] smaller(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic out_t predict_min(input in_t req);
    out_t        res;
    int unsigned cnt, base, lo, hi, l, r;
    logic [VAL_W-1:0] best;
    cnt        = clamped_count();
    base       = leaf_base_for(cnt);
    lo         = 32'(req.range_start);
    hi         = 32'(req.range_end);
    best       = MIN_IDENTITY;
    res.status = 1'b0;
    if (hi > cnt) begin
      hi         = cnt;
      res.status = 1'b1;
    end
    if (lo < hi) begin
      l = lo + base;
      r = hi + base;
      while (l < r) begin
        if (l[0]) begin
          best = smaller(best, tree_mirror[NODE_AW'(l)]);
          l++;
        end
        if (r[0]) begin
          r--;
          best = smaller(best, tree_mirror[NODE_AW'(r)]);
        end
        l = l >> 1;
        r = r >> 1;
      end
    end
    res.minimum = best;
    return res;
  endfunction

  function automatic void mirror_request(input in_t req);
    int unsigned cnt, base, i;
    cnt  = clamped_count();
    base = leaf_base_for(cnt);
    case (req.command)
      CMD_LOAD: begin
        if (32'(req.element_index) < cnt)
          tree_mirror[NODE_AW'(base + 32'(req.element_index))] =
            (req.element_value > MIN_IDENTITY) ? MIN_IDENTITY : req.element_value;
      end
      CMD_BUILD: begin
        for (i = base - 1; i > 0; i--)
          tree_mirror[NODE_AW'(i)] = smaller(tree_mirror[NODE_AW'(2 * i)],
                                             tree_mirror[NODE_AW'(2 * i + 1)]);
      end
      CMD_QUERY: pending_minima.push_back(predict_min(req));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic report_error(input string what, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_minima.size() == 0) begin
        report_error("result with no pending query", '0, out_data.minimum);
      end else begin
        want = pending_minima.pop_front();
        minima_checked++;
        if (out_data.minimum !== want.minimum)
          report_error("minimum", want.minimum, out_data.minimum);
        if (out_data.status !== want.status)
          report_error("status", VAL_W'(want.status), VAL_W'(out_data.status));
      end
    end
    out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // valid is left high after acceptance so back-to-back requests need no toggle
  task automatic send_request(input in_t req);
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror_request(req);
    requests_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_element_count(input logic [CNT_W-1:0] value);
    settle_block();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    count_setting  = value;
    settings_used++;
  endtask

  // unused fields carry random bits
  function automatic in_t noisy_request(input logic [1:0] cmd);
    in_t r;
    r.command       = cmd;
    r.element_index = IDX_W'($urandom_range(LEAF_COUNT - 1, 0));
    r.element_value = VAL_W'($urandom());
    r.range_start   = CNT_W'($urandom_range(2047, 0));
    r.range_end     = CNT_W'($urandom_range(2047, 0));
    return r;
  endfunction

  function automatic in_t load_req(input int unsigned idx, input logic [VAL_W-1:0] val);
    in_t r;
    r               = noisy_request(CMD_LOAD);
    r.element_index = IDX_W'(idx);
    r.element_value = val;
    return r;
  endfunction

  function automatic in_t query_req(input int unsigned lo, input int unsigned hi);
    in_t r;
    r             = noisy_request(CMD_QUERY);
    r.range_start = CNT_W'(lo);
    r.range_end   = CNT_W'(hi);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 15) return VAL_W'($urandom_range(15, 0));
    if (pick < 70) return VAL_W'($urandom_range(MIN_IDENTITY, 0));
    return VAL_W'($urandom());
  endfunction

  function automatic in_t random_query(input int unsigned cnt);
    int unsigned pick, lo, hi;
    pick = $urandom_range(99, 0);
    if (pick < 70) begin
      lo = $urandom_range(cnt - 1, 0);
      hi = $urandom_range(cnt, lo + 1);
    end else if (pick < 80) begin
      lo = $urandom_range(cnt, 0);
      hi = $urandom_range(lo, 0);
    end else if (pick < 92) begin
      lo = $urandom_range(cnt, 0);
      hi = $urandom_range(2047, cnt + 1);
    end else begin
      lo = $urandom_range(2047, 0);
      hi = $urandom_range(2047, 0);
    end
    return query_req(lo, hi);
  endfunction

  // mostly small counts so builds stay short
  function automatic logic [CNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 3) return CNT_W'(0);
    if (pick < 5) return CNT_W'(2047);
    if (pick < 8) return CNT_W'(LEAF_COUNT);
    if (pick < 10) return CNT_W'($urandom_range(1100, 513));
    if (pick < 70) return CNT_W'($urandom_range(64, 1));
    return CNT_W'($urandom_range(300, 65));
  endfunction

  // loads, usually a build, then queries, with some noise mixed in
  task automatic run_sequence(output int issued);
    int unsigned cnt, n_loads, n_queries, k, idx;
    cnt       = clamped_count();
    issued    = 0;
    n_loads   = (cnt <= 64) ? cnt + $urandom_range(3, 0) : $urandom_range(40, 10);
    n_queries = $urandom_range(12, 4);
    for (k = 0; k < n_loads; k++) begin
      idx = ($urandom_range(99, 0) < 92) ? $urandom_range(cnt - 1, 0)
                                          : $urandom_range(LEAF_COUNT - 1, 0);
      send_request(load_req(idx, random_value()));
      if (idx < cnt) issued++;
      if ($urandom_range(99, 0) < 3) send_request(noisy_request(CMD_NOP));
    end
    if ($urandom_range(99, 0) < 90) begin
      send_request(noisy_request(CMD_BUILD));
      issued++;
    end
    for (k = 0; k < n_queries; k++) begin
      send_request(random_query(cnt));
      issued++;
      if ($urandom_range(99, 0) < 3) send_request(noisy_request(CMD_NOP));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // internal nodes and leaves are still zero from the clearing pass
  task automatic test_query_after_reset();
    send_request(query_req(0, LEAF_COUNT));
  endtask

  task automatic test_load_build_query();
    set_element_count(CNT_W'(5));
    send_request(load_req(0, VAL_W'('1)));              // saturates
    send_request(load_req(1, MIN_IDENTITY));
    send_request(load_req(2, VAL_W'(MIN_IDENTITY + 1))); // saturates
    send_request(load_req(3, VAL_W'(7)));
    send_request(load_req(4, '0));
    send_request(load_req(5, '0));                      // beyond count, dropped
    send_request(load_req(LEAF_COUNT - 1, '0));         // dropped
    send_request(query_req(0, 5));                      // stale internal nodes
    send_request(noisy_request(CMD_BUILD));
    send_request(query_req(0, 5));
    send_request(query_req(0, 1));
    send_request(query_req(2, 2));                      // empty
    send_request(query_req(4, 1));                      // start past end
    send_request(query_req(1, 2047));                   // end clamped, flagged
    send_request(query_req(2047, 2047));
    send_request(noisy_request(CMD_NOP));
  endtask

  task automatic test_count_extremes();
    set_element_count(CNT_W'(0));                       // acts as one element
    send_request(load_req(0, VAL_W'(3)));
    send_request(noisy_request(CMD_BUILD));
    send_request(query_req(0, 2));
    set_element_count(CNT_W'(2047));                    // acts as full size
    send_request(load_req(LEAF_COUNT - 1, VAL_W'(1)));
    send_request(noisy_request(CMD_BUILD));
    send_request(query_req(0, LEAF_COUNT));
    send_request(query_req(LEAF_COUNT - 1, LEAF_COUNT));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int done, issued;
    sender_gap_pct     = send_pct;
    receiver_stall_pct = recv_pct;
    done               = 0;
    while (done < n_items) begin
      if ($urandom_range(1, 0)) set_element_count(random_count());
      run_sequence(issued);
      done += issued;
    end
  endtask

  initial begin : main
    int k;
    for (k = 0; k < STORE_DEPTH; k++) tree_mirror[NODE_AW'(k)] = '0;
    count_setting      = CNT_RESET;
    sender_gap_pct     = 21;
    receiver_stall_pct = 58;
    error_count        = 0;
    requests_sent      = 0;
    minima_checked     = 0;
    settings_used      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_query_after_reset();
    test_load_build_query();
    test_count_extremes();
    test_random_traffic(21, 58, 330);
    test_random_traffic(58, 21, 330);
    test_random_traffic(0, 0, 330);

    settle_block();
    $display("Sent %0d requests, checked %0d query results over %0d count settings,",
             requests_sent, minima_checked, settings_used);
    $display("under sender/receiver idle mixes 21/58, 58/21 and 0/0; %0d errors.",
             error_count);
    if (error_count == 0 && pending_minima.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
